// File: rtl/kvlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvlp_pkg;

  localparam int KVLP_MAX_LINE = 256;
  localparam int KVLP_QDEPTH   = 4;

  typedef enum logic [2:0] {
    RK_NAME     = 3'd0,
    RK_VALUE    = 3'd1,
    RK_DONE     = 3'd2,
    RK_ERROR    = 3'd3,
    RK_FINISHED = 3'd4
  } kvlp_rkind_t;

  typedef struct packed {
    kvlp_rkind_t rkind;
    logic [7:0]  rdata;
  } kvlp_res_t;

  // all results caused by one input transaction; last_idx = count - 1
  typedef struct packed {
    logic [1:0]      last_idx;
    kvlp_res_t [3:0] res;
  } kvlp_bundle_t;

endpackage

`default_nettype wire

// File: rtl/kvlp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlp_fifo import kvlp_pkg::*; #(
  parameter int DEPTH = KVLP_QDEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire kvlp_bundle_t push_data,
  output logic              full,
  input  wire logic         pop,
  output kvlp_bundle_t      pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  kvlp_bundle_t     slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvlp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlp_front import kvlp_pkg::*; #(
  parameter int MAX_LINE = KVLP_MAX_LINE
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_kind,
  input  wire logic [7:0]   in_text_byte,
  output logic              q_push,
  output kvlp_bundle_t      q_data,
  input  wire logic         q_full
);

  localparam int SLOT_W = $clog2(MAX_LINE);
  localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(MAX_LINE - 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  typedef struct packed {
    logic              in_comment;
    logic              in_entry;
    logic              value_seen;
    logic              stopped;
    logic [SLOT_W-1:0] slot;
  } pst_t;

  // parser state after one byte plus the (at most two) results it made
  typedef struct packed {
    pst_t            s;
    logic [1:0]      n;
    kvlp_res_t [1:0] r;
  } part_t;

  function automatic part_t emit(part_t p, kvlp_rkind_t k, logic [7:0] d);
    part_t o;
    o = p;
    o.r[p.n[0]].rkind = k;
    o.r[p.n[0]].rdata = d;
    o.n = p.n + 2'd1;
    return o;
  endfunction

  function automatic part_t close_entry(part_t p);
    part_t o;
    o = p;
    if (p.s.value_seen) begin
      o = emit(o, RK_DONE, '0);
    end else begin
      o = emit(o, RK_ERROR, '0);
      o.s.stopped = 1'b1;
    end
    o.s.in_entry   = 1'b0;
    o.s.value_seen = 1'b0;
    o.s.slot       = '0;
    return o;
  endfunction

  function automatic part_t take_byte(pst_t s, logic [7:0] c);
    part_t o;
    logic  blank;
    o.s   = s;
    o.n   = '0;
    o.r   = '0;
    blank = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    if (!s.stopped) begin
      if (s.in_comment) begin
        if (c == CH_LF || c == CH_NUL) begin
          o.s.in_comment = 1'b0;
        end
      end else if (!s.in_entry && (c == CH_HASH || c == CH_SEMI)) begin
        o.s.in_comment = 1'b1;
      end else if (!s.in_entry && blank) begin
        o.s.in_entry = 1'b0;
      end else begin
        o.s.in_entry = 1'b1;
        if (c == CH_LF) begin
          o = close_entry(o);
        end else begin
          if (c == CH_EQ && !o.s.value_seen) begin
            o.s.value_seen = 1'b1;
          end else begin
            o = emit(o, o.s.value_seen ? RK_VALUE : RK_NAME, c);
          end
          o.s.slot = o.s.slot + 1'b1;
          if (o.s.slot == SLOT_FULL) begin
            o = close_entry(o);
          end
        end
      end
    end
    return o;
  endfunction

  function automatic part_t take_end(pst_t s);
    part_t o;
    o.s = s;
    o.n = '0;
    o.r = '0;
    if (!s.stopped) begin
      o.s.in_comment = 1'b0;
      if (s.in_entry) begin
        o = close_entry(o);
      end
      if (!o.s.stopped) begin
        o = emit(o, RK_FINISHED, '0);
        o.s.stopped = 1'b1;
      end
    end
    return o;
  endfunction

  pst_t         st_r, st_nxt;
  logic         cr_r, cr_nxt;
  part_t        first, second;
  logic [2:0]   total;
  kvlp_bundle_t bundle;
  logic         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // a held CR goes through first unless this byte is the LF that absorbs it
    if (cr_r && !(!in_kind && in_text_byte == CH_LF)) begin
      first = take_byte(st_r, CH_CR);
    end else begin
      first.s = st_r;
      first.n = '0;
      first.r = '0;
    end
    if (in_kind) begin
      second = take_end(first.s);
    end else if (in_text_byte != CH_CR) begin
      second = take_byte(first.s, in_text_byte);
    end else begin
      second.s = first.s;
      second.n = '0;
      second.r = '0;
    end
    st_nxt = second.s;
    cr_nxt = st_r.stopped ? cr_r : (!in_kind && in_text_byte == CH_CR);
  end

  always_comb begin
    total           = {1'b0, first.n} + {1'b0, second.n};
    bundle.res      = '0;
    bundle.last_idx = 2'(total - 3'd1);
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < first.n) begin
        bundle.res[i] = first.r[i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < second.n) begin
        bundle.res[first.n + 2'(i)] = second.r[i];
      end
    end
  end

  assign q_push = accept && (total != '0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      cr_r <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
      cr_r <= cr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvlp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kvlp_back import kvlp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire kvlp_bundle_t q_data,
  input  wire logic         q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_result_kind,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  kvlp_bundle_t cur_r, cur_nxt;
  logic         cur_valid_r, cur_valid_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         at_last;
  logic         taken;

  assign at_last         = (idx_r == cur_r.last_idx);
  assign taken           = cur_valid_r && out_ready;
  assign out_valid       = cur_valid_r;
  assign out_result_kind = cur_r.res[idx_r].rkind;
  assign out_byte        = cur_r.res[idx_r].rdata;
  assign out_last        = at_last;

  // refill from the queue in the same cycle the last result leaves
  assign q_pop = !q_empty && (!cur_valid_r || (taken && at_last));

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (taken) begin
      if (at_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/key_value_line_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | ports                               | handshake
// input   | in  | in_kind, in_text_byte               | in_valid / in_ready
// result  | out | out_result_kind, out_byte, out_last | out_valid / out_ready
//
// One input transaction is taken per cycle while the result queue has room.
// The front parser settles each input in the cycle it is accepted; its results
// (up to four) go to a QDEPTH-deep queue as one bundle.
// The back end sends one result per cycle while out_ready is high; the output port
// rate is what limits sustained throughput. Each result is registered in a queue
// slot and then in the back end's current-bundle register before it is output.
// Synchronous active-low reset clears parser flags, queue and output valid.

module key_value_line_parser_unit import kvlp_pkg::*; #(
  parameter int MAX_LINE = KVLP_MAX_LINE,
  parameter int QDEPTH   = KVLP_QDEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_text_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_result_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic         q_push, q_full, q_pop, q_empty;
  kvlp_bundle_t q_wdata, q_rdata;

  kvlp_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_text_byte (in_text_byte),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  kvlp_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  kvlp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  // the parser stops after finished or error, so nothing can follow them
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_FINISHED || out_result_kind == RK_ERROR)
    |-> out_last)
    else $error("finished/error result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RK_NAME && out_result_kind != RK_VALUE
    |-> out_byte == 8'h00)
    else $error("status result carries nonzero byte");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> !q_empty)
    else $error("result queue lost entries");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kvlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 150;
  localparam int RANDOM_ITEMS   = 100;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  typedef struct {
    kvlp_rkind_t kind;
    logic [7:0]  data;
    logic        last;
  } parse_result_t;

  typedef logic [7:0] byte_seq_t [$];

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_kind;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_result_kind;
  logic [7:0] out_byte;
  logic       out_last;

  key_value_line_parser_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_text_byte(in_text_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always #4 clk = ~clk;

  // parser state mirror
  logic p_cr_held = 1'b0;
  logic p_in_comment = 1'b0;
  logic p_in_entry = 1'b0;
  logic p_value_seen = 1'b0;
  int   p_slots = 0;
  logic p_stopped = 1'b0;

  parse_result_t step_results[$];
  parse_result_t pending_results[$];
  parse_result_t want;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   errors = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   kind_seen [5] = '{0, 0, 0, 0, 0};
  logic [7:0] blank_set [6] = '{CH_SP, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};

  function automatic void emit_result(kvlp_rkind_t k, logic [7:0] d);
    parse_result_t r;
    if (step_results.size() >= 4) return;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void close_line_entry();
    if (p_value_seen) begin
      emit_result(RK_DONE, 8'h00);
    end else begin
      emit_result(RK_ERROR, 8'h00);
      p_stopped = 1'b1;
    end
    p_in_entry = 1'b0;
    p_value_seen = 1'b0;
    p_slots = 0;
  endfunction

  function automatic void consume_byte(logic [7:0] c);
    if (p_stopped) return;
    if (p_in_comment) begin
      if (c == CH_LF || c == CH_NUL) p_in_comment = 1'b0;
      return;
    end
    if (!p_in_entry) begin
      if (c == CH_HASH || c == CH_SEMI) begin
        p_in_comment = 1'b1;
        return;
      end
      if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) return;
      p_in_entry = 1'b1;
    end
    if (c == CH_EQ && !p_value_seen) begin
      p_value_seen = 1'b1;
    end else if (c == CH_LF) begin
      close_line_entry();
      return;
    end else begin
      emit_result(p_value_seen ? RK_VALUE : RK_NAME, c);
    end
    p_slots++;
    if (p_slots + 1 >= KVLP_MAX_LINE) close_line_entry();
  endfunction

  // expected results of one accepted transaction, appended to pending_results
  function automatic void parse_step(logic k, logic [7:0] b);
    step_results.delete();
    if (!p_stopped) begin
      if (k == KIND_END) begin
        if (p_cr_held) begin
          p_cr_held = 1'b0;
          consume_byte(CH_CR);
        end
        if (!p_stopped) begin
          p_in_comment = 1'b0;
          if (p_in_entry) close_line_entry();
          if (!p_stopped) begin
            emit_result(RK_FINISHED, 8'h00);
            p_stopped = 1'b1;
          end
        end
      end else if (p_cr_held) begin
        if (b == CH_LF) begin
          p_cr_held = 1'b0;
          consume_byte(CH_LF);
        end else begin
          consume_byte(CH_CR);
          if (b != CH_CR) begin
            p_cr_held = 1'b0;
            consume_byte(b);
          end
        end
      end else if (b == CH_CR) begin
        p_cr_held = 1'b1;
      end else begin
        consume_byte(b);
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  function automatic logic [7:0] rand_lead_byte();
    logic [7:0] b;
    b = 8'($urandom_range(8'h21, 8'h7E));
    while (b == CH_HASH || b == CH_SEMI) b = 8'($urandom_range(8'h21, 8'h7E));
    return b;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_name_byte();
    logic [7:0] b;
    b = rand_text_byte();
    while (b == CH_EQ) b = rand_text_byte();
    return b;
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_step(k, b);
    items_sent++;
  endtask

  task automatic send_bytes(input byte_seq_t seq);
    foreach (seq[i]) send_item(KIND_TEXT, seq[i]);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed entries, some comments and blank-only lines
  task automatic send_random_line();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(0, 2)) send_item(KIND_TEXT, blank_set[$urandom_range(0, 5)]);
      if ($urandom_range(0, 4) != 0) begin
        send_item(KIND_TEXT, rand_lead_byte());
        repeat ($urandom_range(0, 3)) send_item(KIND_TEXT, rand_name_byte());
      end
      send_item(KIND_TEXT, CH_EQ);
      repeat ($urandom_range(0, 5)) send_item(KIND_TEXT, rand_text_byte());
      if ($urandom_range(0, 1)) send_item(KIND_TEXT, CH_CR);
      send_item(KIND_TEXT, CH_LF);
    end else if (pick < 90) begin
      send_item(KIND_TEXT, $urandom_range(0, 1) ? CH_HASH : CH_SEMI);
      repeat ($urandom_range(0, 4)) begin
        logic [7:0] b;
        b = rand_text_byte();
        if (b == CH_NUL) b = 8'h80;
        send_item(KIND_TEXT, b);
      end
      case ($urandom_range(0, 2))
        0: send_item(KIND_TEXT, CH_LF);
        1: send_bytes('{CH_CR, CH_LF});
        default: send_item(KIND_TEXT, CH_NUL);
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) send_item(KIND_TEXT, blank_set[$urandom_range(0, 5)]);
      send_item(KIND_TEXT, CH_LF);
    end
  endtask

  task automatic test_directed();
    byte_seq_t seq;
    // blanks, comment closed by NUL, entry opened by NUL with inner blank,
    // extra '=' as value, CR LF fold, ';' comment, CR at line start,
    // empty name, CR before CR and before an ordinary byte
    seq = '{CH_SP, 8'h0B, CH_HASH, 8'h41, CH_NUL,
            CH_NUL, 8'h61, CH_SP, CH_EQ, CH_EQ, 8'hFF, CH_CR, CH_LF,
            CH_SEMI, CH_LF,
            CH_CR, CH_EQ, CH_CR, CH_CR, 8'h80, CH_TAB, CH_LF};
    send_bytes(seq);
    idle_input();
    drain_results();
  endtask

  task automatic test_entry_full();
    send_bytes('{8'h6B, CH_EQ});
    repeat (KVLP_MAX_LINE - 3) send_item(KIND_TEXT, rand_text_byte());
    // rest of the line parses as a fresh one
    send_bytes('{CH_EQ, 8'h76, CH_LF});
    idle_input();
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) send_bytes('{8'h61, 8'h62, CH_EQ, 8'h63, 8'h64, CH_LF});
    idle_input();
    drain_results();
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent < start + RANDOM_ITEMS) begin
      calm = (items_sent > start + 30) && (items_sent < start + 65);
      send_random_line();
    end
    calm = 1'b0;
    idle_input();
    drain_results();
  endtask

  // only one ending per reset: the block stops for good afterwards
  task automatic test_ending();
    case ($urandom_range(0, 4))
      0: begin
        send_bytes('{8'h6B, CH_EQ, 8'h76, CH_CR});
        send_item(KIND_END, 8'($urandom_range(0, 255)));
      end
      1: send_bytes('{8'h61, 8'h62, CH_LF});
      2: begin
        send_bytes('{8'h61, 8'h62});
        send_item(KIND_END, 8'($urandom_range(0, 255)));
      end
      3: begin
        send_item(KIND_TEXT, rand_lead_byte());
        repeat (KVLP_MAX_LINE - 2) send_item(KIND_TEXT, rand_name_byte());
      end
      default: begin
        send_bytes('{CH_HASH, 8'h78});
        send_item(KIND_END, 8'($urandom_range(0, 255)));
      end
    endcase
    // stopped: everything below must be ignored
    repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    idle_input();
    drain_results();
  endtask

  // result receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_result_kind <= 3'd4) kind_seen[out_result_kind]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %02h last %0b", $time,
                 out_result_kind, out_byte, out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind) begin
          $display("%0t: result_kind mismatch: expected %0d, actual %0d", $time,
                   want.kind, out_result_kind);
          errors++;
        end
        if (out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time,
                   want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                   want.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("** key_value_line_parser_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_text_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_entry_full();
    test_backpressure();
    test_random();
    test_ending();

    repeat (20) @(posedge clk);
    $display("Sent %0d transactions: directed lines, full entry, output stall, random lines,",
             items_sent);
    $display("ending; results name %0d value %0d done %0d error %0d finished %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (errors == 0) begin
      $display("** key_value_line_parser_unit: PASSED **");
    end else begin
      $display("** key_value_line_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kvlp_pkg.sv
rtl/kvlp_fifo.sv
rtl/kvlp_front.sv
rtl/kvlp_back.sv
rtl/key_value_line_parser_unit.sv
bench/tb_top.sv
